// File: sv/cal_pkg.sv
package cal_pkg;

    localparam int MAX_ENTRIES_DEF = 16;
    localparam int DATA_WIDTH      = 32;
    localparam int SMALL_W         = 5;

    localparam logic [SMALL_W-1:0] CAP_RESET = 5'd16;

    typedef enum logic [2:0] {
        OP_INSERT = 3'd0,
        OP_APPEND = 3'd1,
        OP_NEXT   = 3'd2,
        OP_READ   = 3'd3,
        OP_REMOVE = 3'd4,
        OP_CLEAR  = 3'd5
    } op_t;

    typedef struct packed {
        logic [2:0]                   op;
        logic signed [DATA_WIDTH-1:0] value;
    } req_t;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] data;
        logic                         ok;
        logic [SMALL_W-1:0]           count;
        logic [SMALL_W-1:0]           position;
    } rsp_t;

    // Qualified edits that the whole chain sees in the same cycle.
    typedef struct packed {
        logic ins;
        logic app;
        logic rem;
    } cell_ctrl_t;

endpackage

// File: sv/cal_cell.sv
module cal_cell #(
    parameter int IDX   = 0,
    parameter int CNT_W = 5
) (
    input  logic                            clk,
    input  cal_pkg::cell_ctrl_t             ctrl,
    input  logic [CNT_W-1:0]                cursor,
    input  logic [CNT_W-1:0]                count,
    input  logic [cal_pkg::DATA_WIDTH-1:0]  value,
    input  logic [cal_pkg::DATA_WIDTH-1:0]  left,
    input  logic [cal_pkg::DATA_WIDTH-1:0]  right,
    output logic [cal_pkg::DATA_WIDTH-1:0]  entry,
    output logic [cal_pkg::DATA_WIDTH-1:0]  rd
);

    localparam logic [CNT_W-1:0] MY_IDX  = CNT_W'(IDX);
    localparam logic [CNT_W-1:0] MY_IDX1 = CNT_W'(IDX + 1);

    logic [cal_pkg::DATA_WIDTH-1:0] entry_reg;
    logic [cal_pkg::DATA_WIDTH-1:0] entry_next;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.ins)
        begin
            if (MY_IDX == cursor)
            begin
                entry_next = value;
            end
            else if ((MY_IDX > cursor) && (MY_IDX <= count))
            begin
                // shift up: take the lower neighbor
                entry_next = left;
            end
        end
        if (ctrl.app && (MY_IDX == count))
        begin
            entry_next = value;
        end
        if (ctrl.rem && (MY_IDX >= cursor) && (MY_IDX1 < count))
        begin
            // shift down: take the upper neighbor
            entry_next = right;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;
    assign rd    = (MY_IDX == cursor) ? entry_reg : '0;

endmodule

// File: sv/cursor_array_list_unit.sv
// Results: a result is registered and appears in the cycle after its request transfer.
// Throughput: one request per cycle while results are taken; the cell chain
// applies a whole insert or remove shift to every cell in the same cycle.
// Reset: count, cursor and the response valid clear, capacity returns to 16;
// list entries hold no reset value and are only read below count.
module cursor_array_list_unit #(
    parameter int MAX_ENTRIES = cal_pkg::MAX_ENTRIES_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       req_valid,
    output logic                       req_ready,
    input  cal_pkg::req_t              req,
    output logic                       rsp_valid,
    input  logic                       rsp_ready,
    output cal_pkg::rsp_t              rsp,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [cal_pkg::SMALL_W-1:0] cfg_data
);

    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int CMP_W = (CNT_W > cal_pkg::SMALL_W) ? CNT_W : cal_pkg::SMALL_W;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ENTRIES);

    logic [cal_pkg::SMALL_W-1:0] capacity_reg;
    logic [CNT_W-1:0]            count_reg, count_next;
    logic [CNT_W-1:0]            cursor_reg, cursor_next;
    logic                        rsp_valid_reg, rsp_valid_next;
    cal_pkg::rsp_t               rsp_reg, rsp_next;

    logic                        accept;
    logic                        has_room;
    logic                        at_item;
    logic [CMP_W-1:0]            count_ext, cursor_ext;
    logic [cal_pkg::DATA_WIDTH-1:0] read_word;
    logic [cal_pkg::DATA_WIDTH-1:0] rsp_data;
    logic                        rsp_ok;
    cal_pkg::cell_ctrl_t         ctrl;

    logic [cal_pkg::DATA_WIDTH-1:0] entry_w [MAX_ENTRIES];
    logic [cal_pkg::DATA_WIDTH-1:0] rd_w    [MAX_ENTRIES];

    assign req_ready = !rsp_valid_reg || rsp_ready;
    assign accept    = req_valid && req_ready;
    assign cfg_ready = 1'b1;

    assign has_room = (CMP_W'(count_reg) < CMP_W'(capacity_reg)) && (count_reg < MAX_CNT);
    assign at_item  = cursor_reg < count_reg;

    always_comb
    begin
        ctrl.ins = accept && (req.op == cal_pkg::OP_INSERT) && has_room;
        ctrl.app = accept && (req.op == cal_pkg::OP_APPEND) && has_room;
        ctrl.rem = accept && (req.op == cal_pkg::OP_REMOVE) && at_item;
    end

    genvar gi;
    generate
        for (gi = 0; gi < MAX_ENTRIES; gi++)
        begin : g_cell
            logic [cal_pkg::DATA_WIDTH-1:0] left_w, right_w;
            if (gi == 0)
            begin : g_first
                assign left_w = '0;
            end
            else
            begin : g_mid_l
                assign left_w = entry_w[gi-1];
            end
            if (gi == MAX_ENTRIES - 1)
            begin : g_last
                assign right_w = '0;
            end
            else
            begin : g_mid_r
                assign right_w = entry_w[gi+1];
            end
            cal_cell #(
                .IDX   (gi),
                .CNT_W (CNT_W)
            ) u_cell (
                .clk    (clk),
                .ctrl   (ctrl),
                .cursor (cursor_reg),
                .count  (count_reg),
                .value  (req.value),
                .left   (left_w),
                .right  (right_w),
                .entry  (entry_w[gi]),
                .rd     (rd_w[gi])
            );
        end
    endgenerate

    // Only the cell at the cursor drives a nonzero word.
    always_comb
    begin
        read_word = '0;
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            read_word = read_word | rd_w[i];
        end
    end

    always_comb
    begin
        count_next  = count_reg;
        cursor_next = cursor_reg;
        rsp_ok      = 1'b0;
        rsp_data    = '0;
        case (req.op)
            cal_pkg::OP_INSERT, cal_pkg::OP_APPEND:
            begin
                if (has_room)
                begin
                    count_next = count_reg + 1'b1;
                    rsp_ok     = 1'b1;
                end
            end
            cal_pkg::OP_NEXT:
            begin
                if (at_item)
                begin
                    cursor_next = cursor_reg + 1'b1;
                    rsp_ok      = 1'b1;
                end
            end
            cal_pkg::OP_READ:
            begin
                if (at_item)
                begin
                    rsp_data = read_word;
                    rsp_ok   = 1'b1;
                end
            end
            cal_pkg::OP_REMOVE:
            begin
                if (at_item)
                begin
                    rsp_data   = read_word;
                    count_next = count_reg - 1'b1;
                    rsp_ok     = 1'b1;
                end
            end
            cal_pkg::OP_CLEAR:
            begin
                count_next  = '0;
                cursor_next = '0;
                rsp_ok      = 1'b1;
            end
            default:
            begin
                rsp_ok = 1'b0;
            end
        endcase
    end

    assign count_ext  = CMP_W'(count_next);
    assign cursor_ext = CMP_W'(cursor_next);

    always_comb
    begin
        rsp_next          = rsp_reg;
        rsp_valid_next    = rsp_valid_reg;
        if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        if (accept)
        begin
            rsp_valid_next    = 1'b1;
            rsp_next.data     = rsp_data;
            rsp_next.ok       = rsp_ok;
            rsp_next.count    = count_ext[cal_pkg::SMALL_W-1:0];
            rsp_next.position = cursor_ext[cal_pkg::SMALL_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg  <= cal_pkg::CAP_RESET;
            count_reg     <= '0;
            cursor_reg    <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                capacity_reg <= cfg_data;
            end
            if (accept)
            begin
                count_reg  <= count_next;
                cursor_reg <= cursor_next;
            end
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_cursor_in_list: assert property (@(posedge clk) disable iff (!rst_n)
        cursor_reg <= count_reg)
        else $error("cursor past end of list");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= MAX_CNT)
        else $error("count above store depth");

    a_clear_result: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (req.op == cal_pkg::OP_CLEAR)) |=>
        (rsp_valid && rsp.ok && (rsp.count == '0) && (rsp.position == '0)))
        else $error("clear did not empty the list");

    a_refused_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp.ok) |-> (rsp.data == '0))
        else $error("refused operation returned data");

    a_full_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (count_reg == MAX_CNT) &&
         ((req.op == cal_pkg::OP_INSERT) || (req.op == cal_pkg::OP_APPEND)))
        |=> $stable(count_reg))
        else $error("write to full list changed count");

endmodule

// File: tb/tb_cursor_array_list_unit.sv
`timescale 1ns / 1ps

module tb_cursor_array_list_unit;

    localparam int LIST_DEPTH  = cal_pkg::MAX_ENTRIES_DEF;
    localparam int CYCLE_LIMIT = 100000;
    localparam int SHOW_LIMIT  = 10;

    localparam logic [2:0] OP_SPARE_A = 3'd6;
    localparam logic [2:0] OP_SPARE_B = 3'd7;

    logic                        clk       = 1'b0;
    logic                        rst_n     = 1'b0;
    logic                        req_valid = 1'b0;
    logic                        req_ready;
    cal_pkg::req_t               req       = '0;
    logic                        rsp_valid;
    logic                        rsp_ready = 1'b0;
    cal_pkg::rsp_t               rsp;
    logic                        cfg_valid = 1'b0;
    logic                        cfg_ready;
    logic [cal_pkg::SMALL_W-1:0] cfg_data  = '0;

    cursor_array_list_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    // list mirror
    logic signed [cal_pkg::DATA_WIDTH-1:0] list_words [LIST_DEPTH];
    int                                    list_len = 0;
    int                                    list_pos = 0;
    logic [cal_pkg::SMALL_W-1:0]           cap_now  = cal_pkg::CAP_RESET;

    cal_pkg::req_t pending_reqs[$];
    cal_pkg::rsp_t expected_rsps[$];
    logic req_took   = 1'b0;
    bit   steady     = 1'b0;
    int   fail_cnt   = 0;
    int   cycle_cnt  = 0;

    function automatic cal_pkg::rsp_t apply_list_op(cal_pkg::req_t r);
        cal_pkg::rsp_t o;
        int            lim;
        int            i;
        o   = '0;
        lim = (int'(cap_now) < LIST_DEPTH) ? int'(cap_now) : LIST_DEPTH;
        case (r.op)
            cal_pkg::OP_INSERT:
                if (list_len < lim)
                begin
                    for (i = list_len; i > list_pos; i--)
                        list_words[i] = list_words[i-1];
                    list_words[list_pos] = r.value;
                    list_len++;
                    o.ok = 1'b1;
                end
            cal_pkg::OP_APPEND:
                if (list_len < lim)
                begin
                    list_words[list_len] = r.value;
                    list_len++;
                    o.ok = 1'b1;
                end
            cal_pkg::OP_NEXT:
                if (list_pos < list_len)
                begin
                    list_pos++;
                    o.ok = 1'b1;
                end
            cal_pkg::OP_READ:
                if (list_pos < list_len)
                begin
                    o.data = list_words[list_pos];
                    o.ok   = 1'b1;
                end
            cal_pkg::OP_REMOVE:
                if (list_pos < list_len)
                begin
                    o.data = list_words[list_pos];
                    for (i = list_pos; i + 1 < list_len; i++)
                        list_words[i] = list_words[i+1];
                    list_len--;
                    o.ok = 1'b1;
                end
            cal_pkg::OP_CLEAR:
                begin
                    list_len = 0;
                    list_pos = 0;
                    o.ok     = 1'b1;
                end
            default:
                o.ok = 1'b0;
        endcase
        o.count    = cal_pkg::SMALL_W'(list_len);
        o.position = cal_pkg::SMALL_W'(list_pos);
        return o;
    endfunction

    // request driver
    always @(negedge clk)
    begin
        if (!rst_n)
            req_valid <= 1'b0;
        else if (req_valid && !req_took)
            req_valid <= 1'b1;
        else if (pending_reqs.size() != 0 && (steady || $urandom_range(0, 99) >= 14))
        begin
            req       <= pending_reqs.pop_front();
            req_valid <= 1'b1;
        end
        else
            req_valid <= 1'b0;
    end

    always @(negedge clk)
        rsp_ready <= rst_n && (steady || $urandom_range(0, 99) >= 14);

    // predict on request transfer, check on result transfer
    always @(posedge clk)
    begin
        cal_pkg::rsp_t want;
        if (rst_n && req_valid && req_ready)
            expected_rsps.push_back(apply_list_op(req));
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (expected_rsps.size() == 0)
            begin
                fail_cnt++;
                if (fail_cnt <= SHOW_LIMIT)
                    $display("unexpected result: data=%0d ok=%0b count=%0d pos=%0d",
                             rsp.data, rsp.ok, rsp.count, rsp.position);
            end
            else
            begin
                want = expected_rsps.pop_front();
                if (rsp.data !== want.data || rsp.ok !== want.ok ||
                    rsp.count !== want.count || rsp.position !== want.position)
                begin
                    fail_cnt++;
                    if (fail_cnt <= SHOW_LIMIT)
                        $display("mismatch: exp %0d %0b %0d %0d, got %0d %0b %0d %0d",
                                 want.data, want.ok, want.count, want.position,
                                 rsp.data, rsp.ok, rsp.count, rsp.position);
                end
            end
        end
        req_took <= rst_n && req_valid && req_ready;
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("tb_cursor_array_list_unit: FAIL");
            $finish;
        end
    end

    task automatic add_req(input logic [2:0] op,
                           input logic [cal_pkg::DATA_WIDTH-1:0] value);
        cal_pkg::req_t r;
        r.op    = op;
        r.value = value;
        pending_reqs.push_back(r);
    endtask

    function automatic logic [2:0] pick_op(input bit fill);
        int r;
        r = $urandom_range(0, 99);
        if (fill)
        begin
            if (r < 30) return cal_pkg::OP_INSERT;
            if (r < 60) return cal_pkg::OP_APPEND;
            if (r < 75) return cal_pkg::OP_NEXT;
            if (r < 85) return cal_pkg::OP_READ;
            if (r < 95) return cal_pkg::OP_REMOVE;
            if (r < 97) return cal_pkg::OP_CLEAR;
            return (r < 98) ? OP_SPARE_A : OP_SPARE_B;
        end
        if (r < 18) return cal_pkg::OP_INSERT;
        if (r < 32) return cal_pkg::OP_APPEND;
        if (r < 54) return cal_pkg::OP_NEXT;
        if (r < 70) return cal_pkg::OP_READ;
        if (r < 92) return cal_pkg::OP_REMOVE;
        if (r < 96) return cal_pkg::OP_CLEAR;
        return (r < 98) ? OP_SPARE_A : OP_SPARE_B;
    endfunction

    function automatic logic [cal_pkg::DATA_WIDTH-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return '0;
            3: return '1;
            default: return $urandom();
        endcase
    endfunction

    task automatic queue_random(input int n, input bit fill);
        int k;
        for (k = 0; k < n; k++)
            add_req(pick_op(fill), pick_value());
    endtask

    // hold until no request is in flight and every result has come back
    task automatic wait_idle();
        do
            @(posedge clk);
        while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0);
    endtask

    task automatic write_capacity(input logic [cal_pkg::SMALL_W-1:0] cap);
        wait_idle();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= cap;
        do
            @(posedge clk);
        while (!cfg_ready);
        cap_now = cap;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        int k;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // empty list, unused codes, value extremes, cursor walk to the end
        add_req(cal_pkg::OP_READ, 32'd0);
        add_req(cal_pkg::OP_REMOVE, 32'd0);
        add_req(cal_pkg::OP_NEXT, 32'd0);
        add_req(OP_SPARE_A, 32'hffff_ffff);
        add_req(OP_SPARE_B, 32'h1234_5678);
        add_req(cal_pkg::OP_APPEND, 32'h7fff_ffff);
        add_req(cal_pkg::OP_APPEND, 32'h8000_0000);
        add_req(cal_pkg::OP_INSERT, 32'hffff_ffff);
        add_req(cal_pkg::OP_NEXT, 32'd0);
        add_req(cal_pkg::OP_READ, 32'd0);
        add_req(cal_pkg::OP_REMOVE, 32'd0);
        add_req(cal_pkg::OP_NEXT, 32'd0);
        add_req(cal_pkg::OP_NEXT, 32'd0);
        add_req(cal_pkg::OP_READ, 32'd0);
        add_req(cal_pkg::OP_CLEAR, 32'd0);

        // full list at a small capacity
        write_capacity(5'd2);
        add_req(cal_pkg::OP_APPEND, 32'd1);
        add_req(cal_pkg::OP_INSERT, 32'd2);
        add_req(cal_pkg::OP_APPEND, 32'd3);
        add_req(cal_pkg::OP_INSERT, 32'd4);

        // zero capacity refuses every insert and append
        write_capacity(5'd0);
        add_req(cal_pkg::OP_APPEND, 32'd5);
        add_req(cal_pkg::OP_INSERT, 32'd6);
        add_req(cal_pkg::OP_READ, 32'd0);

        write_capacity(5'd31);
        queue_random(130, 1'b0);
        write_capacity(5'd1);
        queue_random(100, 1'b0);
        write_capacity(5'd5);
        queue_random(130, 1'b0);
        write_capacity(5'd16);
        queue_random(130, 1'b1);
        for (k = 0; k < 6; k++)
            add_req(cal_pkg::OP_APPEND, pick_value());

        // drop the capacity under the current length
        write_capacity(5'd3);
        queue_random(130, 1'b0);

        write_capacity(5'd8);
        wait_idle();
        steady = 1'b1;
        queue_random(130, 1'b1);
        wait_idle();
        steady = 1'b0;

        write_capacity(5'd16);
        queue_random(130, 1'b0);

        wait_idle();
        repeat (4) @(posedge clk);
        if (expected_rsps.size() != 0)
            fail_cnt++;
        if (fail_cnt == 0)
            $display("tb_cursor_array_list_unit: PASS");
        else
            $display("tb_cursor_array_list_unit: FAIL");
        $finish;
    end

endmodule

// File: files.f
sv/cal_pkg.sv
sv/cal_cell.sv
sv/cursor_array_list_unit.sv
tb/tb_cursor_array_list_unit.sv
